// File: hw/rtl/eight_bit_cpu_alu_with_flags_core_assert.svh
// Assertion macros used by the ALU top-level RTL file.
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_CORE_ASSERT_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ALU8F_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, checked at every rising edge outside reset.
`define ALU8F_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// File: hw/rtl/alu8f_pkg.sv
// Types shared by the ALU datapath and its top level.
`default_nettype none
package alu8f_pkg;

  // Operation codes, as carried in req_type
  typedef enum logic [2:0] {
    OP_ADD8     = 3'd0,
    OP_SUB8     = 3'd1,
    OP_ADD16_LO = 3'd2,
    OP_ADD16_HI = 3'd3,
    OP_SHIFT    = 3'd4,
    OP_SRA      = 3'd5,
    OP_ROT      = 3'd6,
    OP_ROTC     = 3'd7
  } op_t;

  // Bit position of C in the flags byte
  localparam int unsigned FLAG_C_BIT = 4;
  localparam logic [3:0]  NIB_ZERO   = 4'h0;

  // One captured request
  typedef struct packed {
    op_t         op;
    logic [15:0] x;
    logic [15:0] y;
    logic        cin;
    logic        right;
    logic [7:0]  flags;
  } req_t;

  // One result with its flags
  typedef struct packed {
    logic [15:0] value;
    logic        z;
    logic        n;
    logic        h;
    logic        c;
  } res_t;

endpackage
`default_nettype wire

// File: hw/rtl/alu8f_exec.sv
// Combinational ALU datapath: adders, subtractor, shifter and flag logic.
`default_nettype none
module alu8f_exec
  import alu8f_pkg::*;
(
  input  req_t req,
  output res_t res
);

  // Nibble-wise 8-bit add: {c, h, sum}
  function automatic logic [9:0] add_byte(input logic [7:0] a, input logic [7:0] b,
                                          input logic ci);
    logic [4:0] lo;
    logic [4:0] hi;
    lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, ci};
    hi = {1'b0, a[7:4]} + {1'b0, b[7:4]} + {4'b0, lo[4]};
    return {hi[4], lo[4], hi[3:0], lo[3:0]};
  endfunction

  // Nibble-wise 8-bit subtract: {borrow, half borrow, diff}
  function automatic logic [9:0] sub_byte(input logic [7:0] a, input logic [7:0] b,
                                          input logic bi);
    logic [4:0] lo;
    logic [4:0] hi;
    lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, bi};
    hi = {1'b0, a[7:4]} - {1'b0, b[7:4]} - {4'b0, lo[4]};
    return {hi[4], lo[4], hi[3:0], lo[3:0]};
  endfunction

  logic [9:0] add8_w;
  logic [9:0] sub8_w;
  logic [9:0] add_lo_w;
  logic [9:0] add_hi_w;
  logic       fc_w;
  logic [7:0] xb;
  logic [15:0] value;
  logic       h;
  logic       c;
  logic       n;

  assign xb       = req.x[7:0];
  assign add8_w   = add_byte(req.x[7:0], req.y[7:0], req.cin);
  assign sub8_w   = sub_byte(req.x[7:0], req.y[7:0], req.cin);
  assign add_lo_w = add_byte(req.x[7:0], req.y[7:0], 1'b0);
  assign add_hi_w = add_byte(req.x[15:8], req.y[15:8], add_lo_w[9]);

  // incoming carry counts only with a clean low nibble
  assign fc_w = (req.flags[3:0] == NIB_ZERO) ? req.flags[FLAG_C_BIT] : 1'b0;

  // operation select
  always_comb begin
    value = 16'h0000;
    h     = 1'b0;
    c     = 1'b0;
    n     = 1'b0;
    unique case (req.op)
      OP_ADD8: begin
        value = {8'h00, add8_w[7:0]};
        h     = add8_w[8];
        c     = add8_w[9];
      end
      OP_SUB8: begin
        value = {8'h00, sub8_w[7:0]};
        h     = sub8_w[8];
        c     = sub8_w[9];
        n     = 1'b1;
      end
      OP_ADD16_LO: begin
        value = {add_hi_w[7:0], add_lo_w[7:0]};
        h     = add_lo_w[8];
        c     = add_lo_w[9];
      end
      OP_ADD16_HI: begin
        value = {add_hi_w[7:0], add_lo_w[7:0]};
        h     = add_hi_w[8];
        c     = add_hi_w[9];
      end
      OP_SHIFT: begin
        if (req.right) begin
          value = {8'h00, 1'b0, xb[7:1]};
          c     = xb[0];
        end else begin
          value = {8'h00, xb[6:0], 1'b0};
          c     = xb[7];
        end
      end
      OP_SRA: begin
        value = {8'h00, xb[7], xb[7:1]};
        c     = xb[0];
      end
      OP_ROT: begin
        if (req.right) begin
          value = {8'h00, xb[0], xb[7:1]};
          c     = xb[0];
        end else begin
          value = {8'h00, xb[6:0], xb[7]};
          c     = xb[7];
        end
      end
      OP_ROTC: begin
        if (req.right) begin
          value = {8'h00, fc_w, xb[7:1]};
          c     = xb[0];
        end else begin
          value = {8'h00, xb[6:0], fc_w};
          c     = xb[7];
        end
      end
      default: begin
        value = 16'h0000;
      end
    endcase
  end

  assign res.value = value;
  assign res.z     = (value == 16'h0000);
  assign res.n     = n;
  assign res.h     = h;
  assign res.c     = c;

endmodule
`default_nettype wire

// File: hw/rtl/eight_bit_cpu_alu_with_flags_core.sv
// Top level of the 8-bit CPU ALU with Z, N, H and C flags.
//
// Usage: a request (operation code, two 16-bit operands, carry-in, shift
// direction, flags byte) is taken on the in_ channel when in_valid and
// in_ready are both high. The result value and its four flags come out on
// the out_ channel and are taken when out_valid and out_ready are high.
// The request sits in the input register while the ALU logic settles; it
// moves into the result register, raising out_valid, once that slot is free
// or draining. Throughput is one request per cycle while out_ready stays
// high; each request gives one result. The rate is set by the single pass
// through the adder/shifter between the two registers.
// When the receiver stalls, the result register holds; the input register
// still takes one more request, after which in_ready drops until out_ready
// returns. Results leave in request order.
// Synchronous active-low reset empties both stages; nothing is pending.
`default_nettype none
`include "eight_bit_cpu_alu_with_flags_core_assert.svh"
module eight_bit_cpu_alu_with_flags_core
  import alu8f_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [15:0] in_operand_x,
  input  wire logic [15:0] in_operand_y,
  input  wire logic        in_carry_in,
  input  wire logic        in_direction,
  input  wire logic [7:0]  in_flags_in,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [15:0] out_result_value,
  output      logic        out_zero_flag,
  output      logic        out_subtract_flag,
  output      logic        out_half_carry_flag,
  output      logic        out_carry_flag
);

  logic stage_v_r;
  logic stage_v_nxt;
  req_t stage_r;
  logic out_valid_r;
  logic out_valid_nxt;
  res_t out_res_r;
  res_t exec_res;
  logic stage_adv;
  logic in_take;

  // handshake: stage moves when the result slot is free or draining
  assign stage_adv = stage_v_r && (!out_valid_r || out_ready);
  assign in_ready  = !stage_v_r || stage_adv;
  assign in_take   = in_valid && in_ready;

  assign stage_v_nxt   = in_take || (stage_v_r && !stage_adv);
  assign out_valid_nxt = stage_adv || (out_valid_r && !out_ready);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stage_v_r   <= stage_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_r.op    <= op_t'(in_req_type);
      stage_r.x     <= in_operand_x;
      stage_r.y     <= in_operand_y;
      stage_r.cin   <= in_carry_in;
      stage_r.right <= in_direction;
      stage_r.flags <= in_flags_in;
    end
  end

  alu8f_exec u_exec (
    .req (stage_r),
    .res (exec_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (stage_adv) begin
      out_res_r <= exec_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_value    = out_res_r.value;
  assign out_zero_flag       = out_res_r.z;
  assign out_subtract_flag   = out_res_r.n;
  assign out_half_carry_flag = out_res_r.h;
  assign out_carry_flag      = out_res_r.c;

  // checks
  `ALU8F_ASSERT_NEXT(a_stage_holds, clk, rst_n, stage_v_r && out_valid_r && !out_ready, stage_v_r && $stable(stage_r))
  `ALU8F_ASSERT_NEXT(a_take_fills, clk, rst_n, in_take, stage_v_r)
  `ALU8F_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, stage_adv, out_valid_r && (out_subtract_flag == ($past(stage_r.op) == OP_SUB8)))
  `ALU8F_ASSERT_IMPL(a_zero_match, clk, rst_n, out_valid_r, out_zero_flag == (out_result_value == 16'h0000))

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the 8-bit ALU with Z/N/H/C flags.
`timescale 1ns / 1ps
module tb_top;
  import alu8f_pkg::*;

  localparam int RANDOM_REQS = 950;
  localparam int MAX_SHOWN   = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_req_type = '0;
  logic [15:0] in_operand_x = '0;
  logic [15:0] in_operand_y = '0;
  logic        in_carry_in = 1'b0;
  logic        in_direction = 1'b0;
  logic [7:0]  in_flags_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_result_value;
  logic        out_zero_flag;
  logic        out_subtract_flag;
  logic        out_half_carry_flag;
  logic        out_carry_flag;

  eight_bit_cpu_alu_with_flags_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_operand_x        (in_operand_x),
    .in_operand_y        (in_operand_y),
    .in_carry_in         (in_carry_in),
    .in_direction        (in_direction),
    .in_flags_in         (in_flags_in),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_value    (out_result_value),
    .out_zero_flag       (out_zero_flag),
    .out_subtract_flag   (out_subtract_flag),
    .out_half_carry_flag (out_half_carry_flag),
    .out_carry_flag      (out_carry_flag)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  req_t pending_reqs[$];       // requests not yet sent
  res_t predicted_results[$];  // expected ALU outputs, oldest first
  req_t cur_req;
  int   accepted_cnt = 0;
  int   checked_cnt = 0;
  int   fault_cnt = 0;
  int   directed_cnt = 0;
  int   op_hits[8];
  int   send_idle_pct = 31;
  int   recv_idle_pct = 46;

  // 8-bit add by nibbles: returns {carry, half carry, sum}
  function automatic logic [9:0] nibble_add(logic [7:0] a, logic [7:0] b, logic ci);
    logic [4:0] lo;
    logic [4:0] hi;
    lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
    hi = {1'b0, a[7:4]} + {1'b0, b[7:4]} + {4'd0, lo[4]};
    return {hi[4], lo[4], hi[3:0], lo[3:0]};
  endfunction

  // Expected value and flags for one request
  function automatic res_t alu_predict(req_t r);
    res_t       res;
    logic [7:0] xb;
    logic [4:0] lo;
    logic [4:0] hi;
    logic [9:0] low_sum;
    logic [9:0] high_sum;
    logic       cflag_in;
    xb = r.x[7:0];
    res = '0;
    case (r.op)
      OP_ADD8: begin
        low_sum = nibble_add(xb, r.y[7:0], r.cin);
        res.value = {8'h00, low_sum[7:0]};
        res.h = low_sum[8];
        res.c = low_sum[9];
      end
      OP_SUB8: begin
        // borrow shows up as the sign bit of the 5-bit nibble difference
        lo = {1'b0, xb[3:0]} - {1'b0, r.y[3:0]} - {4'd0, r.cin};
        hi = {1'b0, xb[7:4]} - {1'b0, r.y[7:4]} - {4'd0, lo[4]};
        res.value = {8'h00, hi[3:0], lo[3:0]};
        res.n = 1'b1;
        res.h = lo[4];
        res.c = hi[4];
      end
      OP_ADD16_LO, OP_ADD16_HI: begin
        low_sum = nibble_add(xb, r.y[7:0], 1'b0);
        high_sum = nibble_add(r.x[15:8], r.y[15:8], low_sum[9]);
        res.value = {high_sum[7:0], low_sum[7:0]};
        if (r.op == OP_ADD16_HI) begin
          res.h = high_sum[8];
          res.c = high_sum[9];
        end else begin
          res.h = low_sum[8];
          res.c = low_sum[9];
        end
      end
      OP_SHIFT: begin
        if (r.right) begin
          res.value = {9'd0, xb[7:1]};
          res.c = xb[0];
        end else begin
          res.value = {8'h00, xb[6:0], 1'b0};
          res.c = xb[7];
        end
      end
      OP_SRA: begin
        res.value = {8'h00, xb[7], xb[7:1]};
        res.c = xb[0];
      end
      OP_ROT: begin
        if (r.right) begin
          res.value = {8'h00, xb[0], xb[7:1]};
          res.c = xb[0];
        end else begin
          res.value = {8'h00, xb[6:0], xb[7]};
          res.c = xb[7];
        end
      end
      OP_ROTC: begin
        // incoming C only counts when the low nibble of flags is clear
        cflag_in = (r.flags[3:0] == NIB_ZERO) ? r.flags[FLAG_C_BIT] : 1'b0;
        if (r.right) begin
          res.value = {8'h00, cflag_in, xb[7:1]};
          res.c = xb[0];
        end else begin
          res.value = {8'h00, xb[6:0], cflag_in};
          res.c = xb[7];
        end
      end
    endcase
    res.z = (res.value == 16'h0000);
    return res;
  endfunction

  function automatic req_t make_req(op_t op, logic [15:0] x, logic [15:0] y,
                                    logic cin, logic right, logic [7:0] flags);
    req_t r;
    r.op = op;
    r.x = x;
    r.y = y;
    r.cin = cin;
    r.right = right;
    r.flags = flags;
    return r;
  endfunction

  // Random byte biased toward carry/borrow boundaries
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h0F;
      3: return 8'hF0;
      4: return 8'h80;
      5: return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_fault(string what, res_t want, res_t got);
    fault_cnt++;
    if (fault_cnt <= MAX_SHOWN)
      $display("[%0t] %s: expected value=%h z%b n%b h%b c%b, got value=%h z%b n%b h%b c%b",
               $time, what, want.value, want.z, want.n, want.h, want.c,
               got.value, got.z, got.n, got.h, got.c);
  endtask

  // Request driver: holds each request until taken
  always @(posedge clk) begin : drive_requests
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_results.push_back(alu_predict(cur_req));
        op_hits[cur_req.op]++;
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= cur_req.op;
          in_operand_x <= cur_req.x;
          in_operand_y <= cur_req.y;
          in_carry_in <= cur_req.cin;
          in_direction <= cur_req.right;
          in_flags_in <= cur_req.flags;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result monitor
  always @(posedge clk) begin : check_results
    res_t  got;
    res_t  want;
    string diff;
    if (rst_n && out_valid && out_ready) begin
      got.value = out_result_value;
      got.z = out_zero_flag;
      got.n = out_subtract_flag;
      got.h = out_half_carry_flag;
      got.c = out_carry_flag;
      if (predicted_results.size() == 0) begin
        report_fault("result with no request pending", '0, got);
      end else begin
        want = predicted_results.pop_front();
        checked_cnt++;
        diff = "";
        if (got.value !== want.value) diff = {diff, " value"};
        if (got.z !== want.z) diff = {diff, " Z"};
        if (got.n !== want.n) diff = {diff, " N"};
        if (got.h !== want.h) diff = {diff, " H"};
        if (got.c !== want.c) diff = {diff, " C"};
        if (diff != "") report_fault({"wrong", diff}, want, got);
      end
    end
  end

  // Stimulus and end of test
  initial begin : stimulus
    int   total;
    logic [3:0] f_hi;
    // directed: flag boundaries of every operation
    pending_reqs.push_back(make_req(OP_ADD8, 16'h00FF, 16'h0001, 1'b0, 1'b1, 8'hFF));
    pending_reqs.push_back(make_req(OP_ADD8, 16'hAB0F, 16'hCD00, 1'b1, 1'b0, 8'h00));
    pending_reqs.push_back(make_req(OP_ADD8, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h10));
    pending_reqs.push_back(make_req(OP_ADD8, 16'h007F, 16'h0080, 1'b1, 1'b1, 8'h00));
    pending_reqs.push_back(make_req(OP_SUB8, 16'h0000, 16'h0001, 1'b0, 1'b0, 8'hFF));
    pending_reqs.push_back(make_req(OP_SUB8, 16'h0010, 16'h0001, 1'b0, 1'b1, 8'h10));
    pending_reqs.push_back(make_req(OP_SUB8, 16'hFF00, 16'h1200, 1'b1, 1'b0, 8'h00));
    pending_reqs.push_back(make_req(OP_SUB8, 16'h00FF, 16'h00FF, 1'b0, 1'b0, 8'h00));
    pending_reqs.push_back(make_req(OP_ADD16_LO, 16'hFFFF, 16'h0001, 1'b1, 1'b0, 8'h00));
    pending_reqs.push_back(make_req(OP_ADD16_HI, 16'hFFFF, 16'h0001, 1'b1, 1'b1, 8'hFF));
    pending_reqs.push_back(make_req(OP_ADD16_LO, 16'h0FFF, 16'h0001, 1'b0, 1'b0, 8'h00));
    pending_reqs.push_back(make_req(OP_ADD16_HI, 16'h0FFF, 16'h0001, 1'b0, 1'b0, 8'h00));
    pending_reqs.push_back(make_req(OP_ADD16_HI, 16'h00FF, 16'h0001, 1'b0, 1'b0, 8'h00));
    pending_reqs.push_back(make_req(OP_SHIFT, 16'h0080, 16'hFFFF, 1'b1, 1'b0, 8'hFF));
    pending_reqs.push_back(make_req(OP_SHIFT, 16'h0001, 16'hFFFF, 1'b1, 1'b1, 8'h10));
    pending_reqs.push_back(make_req(OP_SHIFT, 16'hFF81, 16'h0000, 1'b0, 1'b0, 8'h00));
    pending_reqs.push_back(make_req(OP_SRA, 16'h0081, 16'h0000, 1'b0, 1'b0, 8'h00));
    pending_reqs.push_back(make_req(OP_SRA, 16'h0080, 16'h0000, 1'b1, 1'b1, 8'h10));
    pending_reqs.push_back(make_req(OP_ROT, 16'h0080, 16'h0000, 1'b0, 1'b0, 8'h10));
    pending_reqs.push_back(make_req(OP_ROT, 16'h0001, 16'h0000, 1'b1, 1'b1, 8'h00));
    pending_reqs.push_back(make_req(OP_ROTC, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h10));
    pending_reqs.push_back(make_req(OP_ROTC, 16'h0000, 16'h0000, 1'b1, 1'b1, 8'h11));
    pending_reqs.push_back(make_req(OP_ROTC, 16'h0001, 16'h0000, 1'b0, 1'b1, 8'hF0));
    pending_reqs.push_back(make_req(OP_ROTC, 16'h0080, 16'h0000, 1'b0, 1'b0, 8'h00));
    pending_reqs.push_back(make_req(OP_ROTC, 16'h00FF, 16'hFFFF, 1'b1, 1'b0, 8'hFF));
    directed_cnt = pending_reqs.size();

    // random: half the flag bytes carry a usable C
    for (int i = 0; i < RANDOM_REQS; i++) begin
      f_hi = 4'($urandom_range(15));
      pending_reqs.push_back(make_req(op_t'($urandom_range(7)),
                                      {pick_byte(), pick_byte()},
                                      {pick_byte(), pick_byte()},
                                      1'($urandom_range(1)), 1'($urandom_range(1)),
                                      $urandom_range(1) ? {f_hi, NIB_ZERO} : 8'($urandom)));
    end
    total = pending_reqs.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // idle mix changes by thirds of the run
    while (accepted_cnt < total / 3) @(posedge clk);
    send_idle_pct = 46;
    recv_idle_pct = 31;
    while (accepted_cnt < 2 * total / 3) @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (accepted_cnt < total) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (predicted_results.size() != 0) begin
      fault_cnt += predicted_results.size();
      $display("%0d results never arrived", predicted_results.size());
    end
    if (fault_cnt > MAX_SHOWN)
      $display("%0d further faults not shown", fault_cnt - MAX_SHOWN);
    $display("Ran %0d requests (%0d directed) with mixed backpressure; %0d results checked.",
             accepted_cnt, directed_cnt, checked_cnt);
    $display("Per op: add8 %0d sub8 %0d add16 %0d/%0d shift %0d sra %0d rot %0d rotc %0d",
             op_hits[OP_ADD8], op_hits[OP_SUB8], op_hits[OP_ADD16_LO], op_hits[OP_ADD16_HI],
             op_hits[OP_SHIFT], op_hits[OP_SRA], op_hits[OP_ROT], op_hits[OP_ROTC]);
    if (fault_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout: %0d of the requests accepted", accepted_cnt);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/alu8f_pkg.sv
hw/rtl/alu8f_exec.sv
hw/rtl/eight_bit_cpu_alu_with_flags_core.sv
tb/tb_top.sv
